// ----- hdl/tgr_pkg.sv -----
`default_nettype none
package tgr_pkg;

    localparam int COORD_BITS  = 12;
    localparam int POS_BITS    = 13;
    localparam int COLOR_BITS  = 24;
    localparam int GLYPH_WIDTH = 11;
    localparam int GLYPH_ROWS  = 16;
    localparam int LINE_HEIGHT = 20;
    localparam int FIRST_CODE  = 32;
    localparam int LAST_CODE   = 126;
    localparam int GLYPH_COUNT = LAST_CODE - FIRST_CODE + 1;
    localparam int ROW_BITS    = GLYPH_WIDTH * GLYPH_ROWS;

    // floor(w / 11) == (w * WIDTH_RECIP) >> 16 for every 13-bit w.
    localparam logic [12:0] WIDTH_RECIP = 13'd5958;

    localparam logic [7:0] CODE_NEWLINE   = 8'd10;
    localparam logic [7:0] CODE_BACKSPACE = 8'd8;

    localparam logic [2:0] REG_WINDOW_LEFT   = 3'd0;
    localparam logic [2:0] REG_WINDOW_TOP    = 3'd1;
    localparam logic [2:0] REG_WINDOW_WIDTH  = 3'd2;
    localparam logic [2:0] REG_WINDOW_HEIGHT = 3'd3;
    localparam logic [2:0] REG_FG_COLOR      = 3'd4;
    localparam logic [2:0] REG_BG_COLOR      = 3'd5;

    typedef enum logic [1:0] {
        CMD_GLYPH  = 2'd0,
        CMD_FILL   = 2'd1,
        CMD_SCROLL = 2'd2
    } cmd_t;

    // What one input item must draw: an optional fill or scroll, then an
    // optional glyph of eleven columns.
    typedef struct packed {
        logic                  pre_valid;
        cmd_t                  pre_cmd;
        logic [POS_BITS-1:0]   pre_x;
        logic [POS_BITS-1:0]   pre_y;
        logic [POS_BITS-1:0]   pre_w;
        logic [POS_BITS-1:0]   pre_h;
        logic                  glyph_valid;
        logic [POS_BITS-1:0]   glyph_x;
        logic [POS_BITS-1:0]   glyph_y;
        logic [ROW_BITS-1:0]   glyph_row;
    } plan_t;

    // Column 0 is the most significant 16 bits of each row.
    localparam logic [ROW_BITS-1:0] GLYPH_ROM [0:GLYPH_COUNT-1] = '{
        176'h0000_0000_0000_0000_0000_0000_0000_0000_0000_0000_0000,
        176'h0000_0000_0000_003E_33FF_33FF_003E_0000_0000_0000_0000,
        176'h0000_0000_0007_0007_0000_0000_0007_0007_0000_0000_0000,
        176'h0000_0120_1FFE_1FFE_0120_0120_1FFE_1FFE_0120_0000_0000,
        176'h0000_0638_0E3C_0864_3FFF_3FFF_0984_0F1C_0718_0000_0000,
        176'h0000_301E_1C33_071E_01C0_0070_1E1C_3307_1E01_0000_0000,
        176'h0000_1F1E_31B3_20E1_20E1_31B3_1F1E_1B00_3180_0000_0000,
        176'h0000_0000_0000_0000_000B_0007_0000_0000_0000_0000_0000,
        176'h0000_0000_0000_07F0_3FFE_780F_4001_0000_0000_0000_0000,
        176'h0000_0000_0000_4001_780F_3FFE_07F0_0000_0000_0000_0000,
        176'h0000_0080_02A0_03E0_01C0_01C0_03E0_02A0_0080_0000_0000,
        176'h0000_0080_0080_0080_03E0_03E0_0080_0080_0080_0000_0000,
        176'h0000_0000_0000_0000_B000_7000_0000_0000_0000_0000_0000,
        176'h0000_0080_0080_0080_0080_0080_0080_0080_0080_0000_0000,
        176'h0000_0000_0000_0000_3000_3000_0000_0000_0000_0000_0000,
        176'h0000_3000_3C00_0F00_03C0_00F0_003C_000F_0003_0000_0000,
        176'h0000_0FFC_1FFE_3603_2181_2061_301B_1FFE_0FFC_0000_0000,
        176'h0000_2004_2004_2006_3FFF_3FFF_2000_2000_2000_0000_0000,
        176'h0000_380C_3C0E_2603_2301_2181_20C3_207E_203C_0000_0000,
        176'h0000_0C0C_1C0E_3043_2041_2041_3043_1FFE_0FBC_0000_0000,
        176'h0000_0F00_0FE0_08FC_081F_3F83_3F80_0800_0800_0000_0000,
        176'h0000_0C3F_1C3F_3021_2021_2021_3061_1FC1_0F81_0000_0000,
        176'h0000_0FE0_1FF8_305C_2046_2043_30C1_1F81_0F01_0000_0000,
        176'h0000_0001_0001_0001_3C01_3F81_03F1_007F_000F_0000_0000,
        176'h0000_0F1C_1FBE_30E3_2041_2041_30E3_1FBE_0F1C_0000_0000,
        176'h0000_203C_207E_20C3_3081_1881_0E83_07FE_01FC_0000_0000,
        176'h0000_0000_0000_0000_3060_3060_0000_0000_0000_0000_0000,
        176'h0000_0000_0000_0000_B060_7060_0000_0000_0000_0000_0000,
        176'h0000_0080_01C0_0360_0630_0C18_180C_1004_0000_0000_0000,
        176'h0000_0120_0120_0120_0120_0120_0120_0120_0120_0000_0000,
        176'h0000_1004_180C_0C18_0630_0360_01C0_0080_0000_0000_0000,
        176'h0000_0006_0007_0003_3301_33C1_00F3_003F_001E_0000_0000,
        176'h0000_0FFC_1FFE_3003_21E1_23F1_2211_2113_33FE_13FC_0000,
        176'h0000_3FFC_3FFE_0103_0101_0101_0103_3FFE_3FFC_0000_0000,
        176'h0000_3FFF_3FFF_2041_2041_2041_30E3_1FBE_0F1C_0000_0000,
        176'h0000_0FFC_1FFE_3003_2001_2001_3003_1C0E_0C0C_0000_0000,
        176'h0000_3FFF_3FFF_2001_2001_2001_3807_1FFE_07F8_0000_0000,
        176'h0000_3FFF_3FFF_2041_2041_2041_2041_2041_2001_0000_0000,
        176'h0000_3FFF_3FFF_0081_0081_0081_0081_0081_0001_0000_0000,
        176'h0000_0FFC_1FFE_3003_2001_2081_3083_1F8E_0F8C_0000_0000,
        176'h0000_3FFF_3FFF_0040_0040_0040_0040_3FFF_3FFF_0000_0000,
        176'h0000_2001_2001_2001_3FFF_3FFF_2001_2001_2001_0000_0000,
        176'h0000_0C00_1C00_3000_2000_2000_3000_1FFF_0FFF_0000_0000,
        176'h0000_3FFF_3FFF_00C0_01E0_0738_0E1C_3C0F_3003_0000_0000,
        176'h0000_3FFF_3FFF_2000_2000_2000_2000_2000_2000_0000_0000,
        176'h0000_3FFF_3FFF_0078_03C0_03C0_0078_3FFF_3FFF_0000_0000,
        176'h0000_3FFF_3FFF_001C_0070_01C0_0700_3FFF_3FFF_0000_0000,
        176'h0000_0FFC_1FFE_3003_2001_2001_3003_1FFE_0FFC_0000_0000,
        176'h0000_3FFF_3FFF_0081_0081_0081_00C3_007E_003C_0000_0000,
        176'h0000_0FFC_1FFE_3003_2001_6001_F003_9FFE_0FFC_0000_0000,
        176'h0000_3FFF_3FFF_0081_0081_0181_1FC3_3E7E_203C_0000_0000,
        176'h0000_0C3C_1C7E_3063_20E1_21C1_3183_1F8E_0F0C_0000_0000,
        176'h0000_0001_0001_0001_3FFF_3FFF_0001_0001_0001_0000_0000,
        176'h0000_0FFF_1FFF_3000_2000_2000_3000_1FFF_0FFF_0000_0000,
        176'h0000_003F_01FF_0FC0_3C00_3C00_0FC0_01FF_003F_0000_0000,
        176'h0000_01FF_3FFF_3E00_01C0_01C0_3E00_3FFF_01FF_0000_0000,
        176'h0000_3C0F_3F3F_03F0_00C0_00C0_03F0_3F3F_3C0F_0000_0000,
        176'h0000_003F_00FF_01C0_3F80_3F80_01C0_00FF_003F_0000_0000,
        176'h0000_3801_3E01_2781_21C1_2061_2039_201F_2007_0000_0000,
        176'h0000_0000_0000_3FFF_3FFF_2001_2001_0000_0000_0000_0000,
        176'h0000_0003_000F_003C_00F0_03C0_0F00_3C00_3000_0000_0000,
        176'h0000_0000_0000_2001_2001_3FFF_3FFF_0000_0000_0000_0000,
        176'h0000_0004_0004_0006_0003_0003_0006_0006_0004_0000_0000,
        176'h0000_8000_8000_8000_8000_8000_8000_8000_8000_8000_0000,
        176'h0000_0000_0000_0000_0007_000B_0000_0000_0000_0000_0000,
        176'h0000_1E00_3F40_2120_2120_2120_1120_3FE0_3FC0_0000_0000,
        176'h0000_3FFF_3FFF_1040_2020_2020_3060_1FC0_0F80_0000_0000,
        176'h0000_0F80_1FC0_3060_2020_2020_2020_3060_1040_0000_0000,
        176'h0000_0F80_1FC0_3060_2020_2020_1040_3FFF_3FFF_0000_0000,
        176'h0000_0F80_1FC0_3260_2220_2220_2260_33C0_1380_0000_0000,
        176'h0000_0020_0020_3FFE_3FFF_0021_0021_0023_0002_0000_0000,
        176'h0000_4780_4FC0_D860_9020_9020_C840_7FE0_3FE0_0000_0000,
        176'h0000_3FFF_3FFF_0040_0020_0020_0060_3FC0_3F80_0000_0000,
        176'h0000_0000_2020_2020_3FE3_3FE3_2000_2000_0000_0000_0000,
        176'h0000_0000_4000_C020_8020_FFE3_7FE3_0000_0000_0000_0000,
        176'h0000_3FFF_3FFF_0600_0700_0D80_18C0_3060_2020_0000_0000,
        176'h0000_0000_2001_2001_3FFF_3FFF_2000_2000_0000_0000_0000,
        176'h0000_3FE0_3FE0_0060_1FC0_1FC0_0060_3FE0_3FC0_0000_0000,
        176'h0000_3FE0_3FE0_0040_0020_0020_0060_3FC0_3F80_0000_0000,
        176'h0000_0F80_1FC0_3060_2020_2020_3060_1FC0_0F80_0000_0000,
        176'h0000_FFE0_FFE0_1040_2020_2020_3060_1FC0_0F80_0000_0000,
        176'h0000_0F80_1FC0_2020_2020_2020_1040_FFE0_FFE0_0000_0000,
        176'h0000_3FE0_3FE0_00C0_0040_0060_0060_0060_0040_0000_0000,
        176'h0000_10C0_31E0_2120_2320_2620_2420_3C60_1840_0000_0000,
        176'h0000_0000_0020_0020_1FFE_3FFE_2020_2020_0000_0000_0000,
        176'h0000_1FE0_3FE0_2000_2000_2000_1000_3FE0_3FE0_0000_0000,
        176'h0000_03E0_07E0_1C00_3000_3000_1C00_07E0_03E0_0000_0000,
        176'h0000_07E0_3FE0_3800_07C0_07C0_3800_3FE0_07E0_0000_0000,
        176'h0000_3060_3DE0_0D80_0700_0700_0D80_3DE0_3060_0000_0000,
        176'h0000_83E0_8FE0_DC00_7000_3000_1C00_0FE0_03E0_0000_0000,
        176'h0000_3020_3820_2C20_2620_2320_21A0_20E0_2060_0000_0000,
        176'h0000_0000_0000_0080_3FFE_7F7F_4001_4001_0000_0000_0000,
        176'h0000_0000_0000_0000_FF7F_FF7F_0000_0000_0000_0000_0000,
        176'h0000_0000_4001_4001_7F7F_3FFE_0080_0000_0000_0000_0000,
        176'h0000_0002_0002_0001_0001_0002_0002_0001_0001_0000_0000
    };

endpackage
`default_nettype wire

// ----- hdl/tgr_ram.sv -----
`default_nettype none
module tgr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

// ----- hdl/tgr_cmd_seq.sv -----
`default_nettype none
module tgr_cmd_seq (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  load,
    input  wire tgr_pkg::plan_t                        plan,
    input  wire logic [tgr_pkg::COLOR_BITS-1:0]        glyph_color,
    input  wire logic [tgr_pkg::COLOR_BITS-1:0]        fill_color,
    output logic                                       busy,
    output logic                                       out_valid,
    input  wire logic                                  out_stall,
    output tgr_pkg::cmd_t                              command,
    output logic [tgr_pkg::POS_BITS-1:0]               pos_x,
    output logic [tgr_pkg::POS_BITS-1:0]               pos_y,
    output logic [tgr_pkg::POS_BITS-1:0]               rect_width,
    output logic [tgr_pkg::POS_BITS-1:0]               rect_height,
    output logic [tgr_pkg::GLYPH_ROWS-1:0]             column_bits,
    output logic [tgr_pkg::COLOR_BITS-1:0]             color,
    output logic                                       last
);
    import tgr_pkg::*;

    localparam logic [3:0] LAST_COL = 4'(GLYPH_WIDTH - 1);

    plan_t      plan_reg;
    logic       pre_pend_reg;
    logic       glyph_pend_reg;
    logic [3:0] col_reg;
    logic       out_valid_reg;
    logic       advance;
    logic [7:0] col_base;

    assign busy      = pre_pend_reg | glyph_pend_reg;
    assign advance   = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign col_base  = {LAST_COL - col_reg, 4'b0000};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pre_pend_reg   <= 1'b0;
            glyph_pend_reg <= 1'b0;
            col_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                pre_pend_reg   <= plan.pre_valid;
                glyph_pend_reg <= plan.glyph_valid;
                col_reg        <= '0;
            end
            if (advance)
            begin
                if (pre_pend_reg)
                begin
                    out_valid_reg <= 1'b1;
                    pre_pend_reg  <= 1'b0;
                end
                else if (glyph_pend_reg)
                begin
                    out_valid_reg <= 1'b1;
                    col_reg       <= col_reg + 4'd1;
                    if (col_reg == LAST_COL)
                    begin
                        glyph_pend_reg <= 1'b0;
                    end
                end
                else
                begin
                    out_valid_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            plan_reg <= plan;
        end
        if (advance && pre_pend_reg)
        begin
            command     <= plan_reg.pre_cmd;
            pos_x       <= plan_reg.pre_x;
            pos_y       <= plan_reg.pre_y;
            rect_width  <= plan_reg.pre_w;
            rect_height <= plan_reg.pre_h;
            column_bits <= '0;
            color       <= fill_color;
            last        <= !glyph_pend_reg;
        end
        else if (advance && glyph_pend_reg)
        begin
            command     <= CMD_GLYPH;
            pos_x       <= plan_reg.glyph_x + {9'd0, col_reg};
            pos_y       <= plan_reg.glyph_y;
            rect_width  <= POS_BITS'(1);
            rect_height <= POS_BITS'(GLYPH_ROWS);
            column_bits <= plan_reg.glyph_row[col_base +: GLYPH_ROWS];
            color       <= glyph_color;
            last        <= (col_reg == LAST_COL);
        end
    end

endmodule
`default_nettype wire

// ----- hdl/text_terminal_glyph_renderer.sv -----
// With the emitter idle, an accepted item is read from the cursor memory, then decoded, and
// its first command is then loaded into the output register.
// An item emits 0 to 12 commands; the cursor read-decode-write pass and the emitter, which a
// stalled output holds, pace the items, and a new item is buffered while the emitter works.
// Reset (rst_n, asynchronous, active low) restores register defaults and homes the cursor.
`default_nettype none
module text_terminal_glyph_renderer (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic                              action,
    input  wire logic [7:0]                        char_code,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output tgr_pkg::cmd_t                          command,
    output logic [tgr_pkg::POS_BITS-1:0]           pos_x,
    output logic [tgr_pkg::POS_BITS-1:0]           pos_y,
    output logic [tgr_pkg::POS_BITS-1:0]           rect_width,
    output logic [tgr_pkg::POS_BITS-1:0]           rect_height,
    output logic [tgr_pkg::GLYPH_ROWS-1:0]         column_bits,
    output logic [tgr_pkg::COLOR_BITS-1:0]         color,
    output logic                                   last,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [2:0]                        cfg_index,
    input  wire logic [tgr_pkg::COLOR_BITS-1:0]    cfg_data
);
    import tgr_pkg::*;

    localparam int CW = COORD_BITS;

    // Engine states: wait for an item, then decode it with the cursor word just read.
    typedef enum logic [1:0] {
        ST_IDLE   = 2'b01,
        ST_DECODE = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Configuration registers.
    logic [CW-1:0]         win_left_reg;
    logic [CW-1:0]         win_top_reg;
    logic [POS_BITS-1:0]   win_width_reg;
    logic [POS_BITS-1:0]   win_height_reg;
    logic [COLOR_BITS-1:0] glyph_color_reg;
    logic [COLOR_BITS-1:0] fill_color_reg;

    // One-entry input buffer: it lets a new transaction be taken while the emitter is
    // still busy with the commands of the previous one.
    logic       item_valid_reg;
    logic       item_action_reg;
    logic [7:0] item_code_reg;

    // The cursor lives in a small synchronous memory. Until the first write the word is
    // undefined, so the valid flag substitutes the home position.
    logic          cursor_valid_reg;
    logic          rd_en;
    logic          wr_en;
    logic [2*CW-1:0] rd_word;
    logic [2*CW-1:0] wr_word;

    // End of the last full cell of a line, i.e. 11 * floor(width / 11). The quotient
    // comes from a reciprocal multiply registered once per cycle; times 11 is shift-add.
    logic [25:0]         recip_prod;
    logic [9:0]          width_quot_reg;
    logic [POS_BITS-1:0] line_end_x;

    plan_t plan;
    logic  seq_busy;

    logic [CW-1:0] cx;
    logic [CW-1:0] cy;
    logic [CW-1:0] new_cx;
    logic [CW-1:0] new_cy;
    logic [CW-1:0] line_cx;
    logic [CW-1:0] line_cy;
    logic [CW-1:0] adv_cy;
    logic          adv_over;
    logic          adv_clear;
    logic          wrap;
    logic          is_print;
    logic [6:0]    glyph_idx;

    assign cfg_ready = 1'b1;
    assign in_stall  = item_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_left_reg    <= '0;
            win_top_reg     <= '0;
            win_width_reg   <= POS_BITS'(640);
            win_height_reg  <= POS_BITS'(480);
            glyph_color_reg <= COLOR_BITS'(920078);
            fill_color_reg  <= COLOR_BITS'(16777215);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_WINDOW_LEFT:   win_left_reg    <= cfg_data[CW-1:0];
                REG_WINDOW_TOP:    win_top_reg     <= cfg_data[CW-1:0];
                REG_WINDOW_WIDTH:  win_width_reg   <= cfg_data[POS_BITS-1:0];
                REG_WINDOW_HEIGHT: win_height_reg  <= cfg_data[POS_BITS-1:0];
                REG_FG_COLOR:      glyph_color_reg <= cfg_data;
                REG_BG_COLOR:      fill_color_reg  <= cfg_data;
                default:           ;
            endcase
        end
    end

    assign recip_prod = win_width_reg * WIDTH_RECIP;

    always_ff @(posedge clk)
    begin
        width_quot_reg <= recip_prod[25:16];
    end

    assign line_end_x = {3'd0, width_quot_reg} + {width_quot_reg, 3'd0}
                      + {2'd0, width_quot_reg, 1'b0};

    // Input buffer and engine control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg   <= 1'b0;
            state_reg        <= ST_IDLE;
            cursor_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_valid && !in_stall)
            begin
                item_valid_reg <= 1'b1;
            end
            else if (state_reg == ST_DECODE)
            begin
                item_valid_reg <= 1'b0;
            end
            if (wr_en)
            begin
                cursor_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            item_action_reg <= action;
            item_code_reg   <= char_code;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        rd_en      = 1'b0;
        wr_en      = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid_reg && !seq_busy)
                begin
                    rd_en      = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                wr_en      = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    tgr_ram #(
        .WIDTH(2 * CW),
        .DEPTH(2)
    ) u_cursor_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (1'b0),
        .wr_data (wr_word),
        .rd_en   (rd_en),
        .rd_addr (1'b0),
        .rd_data (rd_word)
    );

    // Decode of one item against the cursor just read. A line advance either steps
    // down, scrolls the window, or clears a window that holds a single line.
    always_comb
    begin
        cx = cursor_valid_reg ? rd_word[CW-1:0] : '0;
        cy = cursor_valid_reg ? rd_word[2*CW-1:CW] : '0;

        adv_over  = ({2'd0, cy} + 14'(2 * LINE_HEIGHT)) > {1'b0, win_height_reg};
        adv_clear = win_height_reg <= POS_BITS'(LINE_HEIGHT);
        if (!adv_over)
        begin
            adv_cy = cy + CW'(LINE_HEIGHT);
        end
        else if (adv_clear)
        begin
            adv_cy = '0;
        end
        else
        begin
            adv_cy = cy;
        end

        wrap      = ({1'b0, cx} + POS_BITS'(GLYPH_WIDTH)) > win_width_reg;
        is_print  = (item_code_reg >= 8'(FIRST_CODE)) && (item_code_reg <= 8'(LAST_CODE));
        glyph_idx = is_print ? 7'(item_code_reg - 8'(FIRST_CODE)) : 7'd0;

        line_cx = wrap ? '0 : cx;
        line_cy = wrap ? adv_cy : cy;

        new_cx = cx;
        new_cy = cy;

        plan.pre_valid   = 1'b0;
        plan.pre_cmd     = (adv_over && !adv_clear) ? CMD_SCROLL : CMD_FILL;
        plan.pre_x       = {1'b0, win_left_reg};
        plan.pre_y       = {1'b0, win_top_reg};
        plan.pre_w       = win_width_reg;
        plan.pre_h       = win_height_reg;
        plan.glyph_valid = 1'b0;
        plan.glyph_x     = {1'b0, win_left_reg} + {1'b0, line_cx};
        plan.glyph_y     = {1'b0, win_top_reg} + {1'b0, line_cy}
                         + POS_BITS'(LINE_HEIGHT - GLYPH_ROWS);
        plan.glyph_row   = GLYPH_ROM[glyph_idx];

        priority if (item_action_reg)
        begin
            plan.pre_valid = 1'b1;
            plan.pre_cmd   = CMD_FILL;
            new_cx         = '0;
            new_cy         = '0;
        end
        else if (item_code_reg == CODE_NEWLINE)
        begin
            plan.pre_valid = adv_over;
            new_cx         = '0;
            new_cy         = adv_cy;
        end
        else if (item_code_reg == CODE_BACKSPACE)
        begin
            plan.pre_cmd = CMD_FILL;
            plan.pre_w   = POS_BITS'(GLYPH_WIDTH);
            plan.pre_h   = POS_BITS'(LINE_HEIGHT);
            plan.pre_y   = {1'b0, win_top_reg} + {1'b0, cy};
            if (cx < CW'(GLYPH_WIDTH))
            begin
                // At the start of a line: back up to the end of the previous line.
                if (cy != '0)
                begin
                    plan.pre_valid = 1'b1;
                    new_cy = (cy >= CW'(LINE_HEIGHT)) ? cy - CW'(LINE_HEIGHT) : '0;
                    new_cx = line_end_x[CW-1:0];
                end
            end
            else
            begin
                plan.pre_valid = 1'b1;
                new_cx         = cx - CW'(GLYPH_WIDTH);
                plan.pre_x     = {1'b0, win_left_reg} + {1'b0, new_cx};
            end
        end
        else if (is_print)
        begin
            plan.pre_valid   = wrap && adv_over;
            plan.glyph_valid = 1'b1;
            new_cx           = line_cx + CW'(GLYPH_WIDTH);
            new_cy           = line_cy;
        end
        else
        begin
            new_cx = cx;
        end
    end

    assign wr_word = {new_cy, new_cx};

    tgr_cmd_seq u_cmd_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (wr_en),
        .plan        (plan),
        .glyph_color (glyph_color_reg),
        .fill_color  (fill_color_reg),
        .busy        (seq_busy),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .command     (command),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .rect_width  (rect_width),
        .rect_height (rect_height),
        .column_bits (column_bits),
        .color       (color),
        .last        (last)
    );

endmodule
`default_nettype wire
